FILE: design/biquad_iir_filter_assert.svh
// ----------------------------------------------------------------------------
// Biquad IIR filter assertion macros
// Shorthand for the concurrent checks used in the filter RTL.
// ----------------------------------------------------------------------------
`ifndef BIQUAD_IIR_FILTER_ASSERT_SVH
`define BIQUAD_IIR_FILTER_ASSERT_SVH

// Check cons in the same cycle as ante.
`define BQF_ASSERT_NOW(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define BQF_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/bqf_pkg.sv
// ----------------------------------------------------------------------------
// Biquad IIR filter package
// Widths, register map, shared types and arithmetic helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package bqf_pkg;

    localparam int CHANNELS       = 2;
    localparam int SAMPLE_BITS    = 24;
    localparam int COEF_FRAC_BITS = 26;
    localparam int COEF_W         = 32;
    localparam int CHAN_W         = 1;
    localparam int NUM_COEFS      = 5;

    localparam int IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PROD_W  = COEF_W + SAMPLE_BITS;
    localparam int ACC_W   = PROD_W + 3;
    localparam int RND_W   = ACC_W - COEF_FRAC_BITS;

    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam int REG_IDX_W  = $clog2(NUM_COEFS);
    localparam int APB_ADDR_W = REG_IDX_W + 2;
    localparam int APB_DATA_W = 32;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]      coef_t;
    typedef logic signed [PROD_W-1:0]      prod_t;
    typedef logic signed [ACC_W-1:0]       acc_t;
    typedef logic [CHAN_W-1:0]             chan_t;
    typedef logic [IDX_W-1:0]              idx_t;
    typedef logic [REG_IDX_W-1:0]          reg_idx_t;

    localparam reg_idx_t REG_B0 = reg_idx_t'(0);
    localparam reg_idx_t REG_B1 = reg_idx_t'(1);
    localparam reg_idx_t REG_B2 = reg_idx_t'(2);
    localparam reg_idx_t REG_A1 = reg_idx_t'(3);
    localparam reg_idx_t REG_A2 = reg_idx_t'(4);

    localparam coef_t COEF_ONE = coef_t'(64'sd1 <<< COEF_FRAC_BITS);

    localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam acc_t    ACC_HALF   = acc_t'(64'sd1 <<< (COEF_FRAC_BITS - 1));

    typedef struct packed {
        coef_t b0;
        coef_t b1;
        coef_t b2;
        coef_t a1;
        coef_t a2;
    } coef_set_t;

    typedef struct packed {
        idx_t    idx;
        chan_t   chan;
        sample_t sample;
    } q_item_t;

    typedef struct packed {
        logic    valid;
        q_item_t item;
    } q_head_t;

    function automatic idx_t chan_index(chan_t ch);
        logic [CHAN_W+IDX_W-1:0] wide;
        wide = {{IDX_W{1'b0}}, ch};
        if (wide >= (CHAN_W+IDX_W)'(CHANNELS))
        begin
            wide = wide - (CHAN_W+IDX_W)'(CHANNELS);
        end
        return wide[IDX_W-1:0];
    endfunction

    function automatic prod_t mul(coef_t c, sample_t s);
        prod_t a;
        prod_t b;
        a = {{(PROD_W-COEF_W){c[COEF_W-1]}}, c};
        b = {{(PROD_W-SAMPLE_BITS){s[SAMPLE_BITS-1]}}, s};
        return a * b;
    endfunction

    function automatic acc_t widen(prod_t p);
        return {{(ACC_W-PROD_W){p[PROD_W-1]}}, p};
    endfunction

endpackage

`default_nettype wire

FILE: design/bqf_regs.sv
// ----------------------------------------------------------------------------
// Biquad IIR filter coefficient registers
// APB register file holding the five Q6.26 coefficients.
// ----------------------------------------------------------------------------
`default_nettype none

module bqf_regs
    import bqf_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output      logic [APB_DATA_W-1:0] prdata,
    output      logic                  pready,
    output      coef_set_t             coefs
);

    coef_t    coef_reg  [NUM_COEFS];
    coef_t    coef_next [NUM_COEFS];
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[APB_ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        coef_next = coef_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_B0, REG_B1, REG_B2, REG_A1, REG_A2:
                begin
                    coef_next[idx] = coef_t'(pwdata);
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_B0, REG_B1, REG_B2, REG_A1, REG_A2:
            begin
                prdata = APB_DATA_W'(coef_reg[idx]);
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COEFS; i++)
            begin
                coef_reg[i] <= (i == 0) ? COEF_ONE : '0;
            end
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

    assign coefs.b0 = coef_reg[REG_B0];
    assign coefs.b1 = coef_reg[REG_B1];
    assign coefs.b2 = coef_reg[REG_B2];
    assign coefs.a1 = coef_reg[REG_A1];
    assign coefs.a2 = coef_reg[REG_A2];

endmodule

`default_nettype wire

FILE: design/bqf_front.sv
// ----------------------------------------------------------------------------
// Biquad IIR filter front end
// Accepts input words, maps the channel to its history set and queues them.
// ----------------------------------------------------------------------------
`default_nettype none

module bqf_front
    import bqf_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output      logic    in_ready,
    input  wire chan_t   in_chan,
    input  wire sample_t in_sample,
    output      q_head_t head,
    input  wire logic    pop
);

    q_item_t             q_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                push;
    q_item_t             item;

    function automatic logic [QPTR_W-1:0] bump(logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    assign in_ready = (count_reg != QCNT_W'(QDEPTH));
    assign push     = in_valid && in_ready;

    assign item.idx    = chan_index(in_chan);
    assign item.chan   = in_chan;
    assign item.sample = in_sample;

    assign head.valid = (count_reg != '0);
    assign head.item  = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

`default_nettype wire

FILE: design/bqf_back.sv
// ----------------------------------------------------------------------------
// Biquad IIR filter back end
// Multiply stage, sum/round/saturate stage, channel history and output word.
// ----------------------------------------------------------------------------
`default_nettype none

module bqf_back
    import bqf_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire coef_set_t coefs,
    input  wire q_head_t   head,
    output      logic      pop,
    output      logic      out_valid,
    input  wire logic      out_ready,
    output      chan_t     out_chan,
    output      sample_t   out_sample,
    output      logic      out_sat
);

    `include "biquad_iir_filter_assert.svh"

    sample_t in_hist_reg  [CHANNELS][2];
    sample_t out_hist_reg [CHANNELS][2];

    logic    s1_valid_reg;
    logic    s1_valid_next;
    idx_t    s1_idx_reg;
    chan_t   s1_chan_reg;
    sample_t s1_sample_reg;
    prod_t   s1_prod_reg [NUM_COEFS];

    logic    out_valid_reg;
    chan_t   out_chan_reg;
    sample_t out_sample_reg;
    logic    out_sat_reg;

    logic    out_free;
    logic    s1_adv;
    logic    hazard;
    logic    issue;

    sample_t x1;
    sample_t x2;
    sample_t y1;
    sample_t y2;

    acc_t                      acc;
    logic signed [RND_W-1:0]   rnd;
    logic                      fits;
    sample_t                   y;
    logic                      sat;

    assign out_free = !out_valid_reg || out_ready;
    assign s1_adv   = s1_valid_reg && out_free;
    assign hazard   = s1_valid_reg && (s1_idx_reg == head.item.idx);
    assign issue    = head.valid && !hazard && (!s1_valid_reg || out_free);
    assign pop      = issue;

    assign x1 = in_hist_reg[head.item.idx][0];
    assign x2 = in_hist_reg[head.item.idx][1];
    assign y1 = out_hist_reg[head.item.idx][0];
    assign y2 = out_hist_reg[head.item.idx][1];

    always_comb
    begin
        if (issue)
        begin
            s1_valid_next = 1'b1;
        end
        else if (out_free)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_comb
    begin
        acc = widen(s1_prod_reg[0]) + widen(s1_prod_reg[1]) + widen(s1_prod_reg[2])
            + widen(s1_prod_reg[3]) + widen(s1_prod_reg[4]) + ACC_HALF;
        rnd  = acc[ACC_W-1:COEF_FRAC_BITS];
        fits = (&rnd[RND_W-1:SAMPLE_BITS-1]) || !(|rnd[RND_W-1:SAMPLE_BITS-1]);
        sat  = !fits;
        if (fits)
        begin
            y = rnd[SAMPLE_BITS-1:0];
        end
        else
        begin
            y = rnd[RND_W-1] ? SAMPLE_MIN : SAMPLE_MAX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                in_hist_reg[c][0]  <= '0;
                in_hist_reg[c][1]  <= '0;
                out_hist_reg[c][0] <= '0;
                out_hist_reg[c][1] <= '0;
            end
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (s1_adv)
            begin
                in_hist_reg[s1_idx_reg][1]  <= in_hist_reg[s1_idx_reg][0];
                in_hist_reg[s1_idx_reg][0]  <= s1_sample_reg;
                out_hist_reg[s1_idx_reg][1] <= out_hist_reg[s1_idx_reg][0];
                out_hist_reg[s1_idx_reg][0] <= y;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_idx_reg     <= head.item.idx;
            s1_chan_reg    <= head.item.chan;
            s1_sample_reg  <= head.item.sample;
            s1_prod_reg[0] <= mul(coefs.b0, head.item.sample);
            s1_prod_reg[1] <= mul(coefs.b1, x1);
            s1_prod_reg[2] <= mul(coefs.b2, x2);
            s1_prod_reg[3] <= mul(coefs.a1, y1);
            s1_prod_reg[4] <= mul(coefs.a2, y2);
        end
        if (s1_adv)
        begin
            out_chan_reg   <= s1_chan_reg;
            out_sample_reg <= y;
            out_sat_reg    <= sat;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_chan   = out_chan_reg;
    assign out_sample = out_sample_reg;
    assign out_sat    = out_sat_reg;

    `BQF_ASSERT_NOW(a_no_stale_issue, clk, rst_n,
        s1_valid_reg && head.valid && (s1_idx_reg == head.item.idx), !issue,
        "issue while same history set in flight")
    `BQF_ASSERT_NEXT(a_issue_fills_s1, clk, rst_n, issue, s1_valid_reg,
        "issued word lost before sum stage")
    `BQF_ASSERT_NEXT(a_hist_tracks_out, clk, rst_n, s1_adv,
        (out_hist_reg[$past(s1_idx_reg)][0] == out_sample_reg)
        && (in_hist_reg[$past(s1_idx_reg)][0] == $past(s1_sample_reg)),
        "history differs from emitted word")
    `BQF_ASSERT_NOW(a_sat_at_limit, clk, rst_n, out_valid_reg && out_sat_reg,
        (out_sample_reg == SAMPLE_MAX) || (out_sample_reg == SAMPLE_MIN),
        "saturated word not at a limit")

endmodule

`default_nettype wire

FILE: design/biquad_iir_filter.sv
// ----------------------------------------------------------------------------
// Biquad IIR filter
// Two-channel direct form I second-order section with APB coefficients.
// ----------------------------------------------------------------------------
// Each input word carries a channel number and a signed Q1.23 sample; each
// output word returns the channel, the filtered sample (rounded half up and
// saturated to 24 bits) and a saturation flag. Coefficients b0, b1, b2, a1,
// a2 are signed Q6.26 at APB byte addresses 0x00 to 0x10, feedback terms
// already negated; b0 resets to 1.0, the rest to zero. Write them only while
// the filter is idle. One word is taken per cycle while successive words
// alternate channel and the output is not stalled; a word for the same
// channel as the one just issued waits until that word leaves the sum
// stage, since its history comes from the multiply and sum stages.
// ----------------------------------------------------------------------------
`default_nettype none

module biquad_iir_filter
    import bqf_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output      logic                  s_axis_tready,
    input  wire logic [23:0]           s_axis_tdata,   // [23:0] sample_in
    input  wire logic [CHAN_W-1:0]     s_axis_tuser,   // [0] channel
    output      logic                  m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output      logic [23:0]           m_axis_tdata,   // [23:0] sample_out
    output      logic [CHAN_W:0]       m_axis_tuser,   // [0] channel_out, [1] saturated
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output      logic [APB_DATA_W-1:0] prdata,
    output      logic                  pready
);

    coef_set_t coefs;
    q_head_t   head;
    logic      pop;
    chan_t     out_chan;
    sample_t   out_sample;
    logic      out_sat;

    bqf_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coefs   (coefs)
    );

    bqf_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_chan   (s_axis_tuser),
        .in_sample (sample_t'(s_axis_tdata)),
        .head      (head),
        .pop       (pop)
    );

    bqf_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .coefs      (coefs),
        .head       (head),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_chan   (out_chan),
        .out_sample (out_sample),
        .out_sat    (out_sat)
    );

    assign m_axis_tdata = 24'(out_sample);
    assign m_axis_tuser = {out_sat, out_chan};

endmodule

`default_nettype wire

FILE: sim/biquad_iir_filter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Biquad IIR filter testbench
// Drives two-channel sample words through the filter under several
// coefficient sets, written and read back over APB. A local fixed-point
// model predicts each output word and the monitor checks every field of it.
// ----------------------------------------------------------------------------
`default_nettype none

module biquad_iir_filter_tb;

    import bqf_pkg::*;

    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_WORDS   = 140;
    localparam int MAX_PRINTS    = 40;

    typedef struct {
        chan_t   chan;
        sample_t sample;
    } filter_word_t;

    typedef struct {
        chan_t   chan;
        sample_t sample;
        logic    sat;
    } filter_result_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [23:0]           s_axis_tdata = '0;   // [23:0] sample_in
    logic [CHAN_W-1:0]     s_axis_tuser = '0;   // [0] channel
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [23:0]           m_axis_tdata;        // [23:0] sample_out
    logic [CHAN_W:0]       m_axis_tuser;        // [0] channel_out, [1] saturated
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    filter_word_t   pending_samples[$];
    filter_result_t expected_outputs[$];

    coef_t   coef_regs [NUM_COEFS];
    sample_t x_hist [CHANNELS][2];
    sample_t y_hist [CHANNELS][2];

    int  words_in = 0;
    int  driven_count = 0;
    int  words_out = 0;
    int  sat_count = 0;
    int  in_stalls = 0;
    int  errors = 0;
    int  idle_cycles = 0;
    int  hold_count = 0;
    bit  quiet = 1'b0;
    bit  hold_req = 1'b0;
    bit  hold_done = 1'b0;

    biquad_iir_filter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic filter_result_t run_biquad(chan_t chan, sample_t x);
        filter_result_t res;
        longint acc;
        longint y;
        int ch;
        ch = int'(chan) % CHANNELS;
        acc = longint'(coef_regs[REG_B0]) * longint'(x)
            + longint'(coef_regs[REG_B1]) * longint'(x_hist[ch][0])
            + longint'(coef_regs[REG_B2]) * longint'(x_hist[ch][1])
            + longint'(coef_regs[REG_A1]) * longint'(y_hist[ch][0])
            + longint'(coef_regs[REG_A2]) * longint'(y_hist[ch][1]);
        acc = acc + (64'sd1 <<< (COEF_FRAC_BITS - 1));
        y = acc >>> COEF_FRAC_BITS;
        res.sat = 1'b0;
        if (y > longint'(SAMPLE_MAX))
        begin
            y = longint'(SAMPLE_MAX);
            res.sat = 1'b1;
        end
        else if (y < longint'(SAMPLE_MIN))
        begin
            y = longint'(SAMPLE_MIN);
            res.sat = 1'b1;
        end
        res.chan = chan;
        res.sample = sample_t'(y);
        x_hist[ch][1] = x_hist[ch][0];
        x_hist[ch][0] = x;
        y_hist[ch][1] = y_hist[ch][0];
        y_hist[ch][0] = res.sample;
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        if (errors <= MAX_PRINTS)
        begin
            $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        end
    endtask

    // Input acceptance, output checking and APB tracking.
    always @(posedge clk)
    begin
        filter_result_t want;
        reg_idx_t idx;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_outputs.push_back(run_biquad(s_axis_tuser, sample_t'(s_axis_tdata)));
                words_in <= words_in + 1;
            end
            else if (s_axis_tvalid)
            begin
                in_stalls++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                words_out++;
                if (m_axis_tuser[1])
                begin
                    sat_count++;
                end
                if (expected_outputs.size() == 0)
                begin
                    report_mismatch("unexpected word", longint'(m_axis_tdata), 0);
                end
                else
                begin
                    want = expected_outputs.pop_front();
                    if (m_axis_tuser[0] !== want.chan)
                    begin
                        report_mismatch("channel_out", longint'(m_axis_tuser[0]),
                                        longint'(want.chan));
                    end
                    if (m_axis_tdata !== want.sample)
                    begin
                        report_mismatch("sample_out", longint'(m_axis_tdata),
                                        longint'(unsigned'(want.sample)));
                    end
                    if (m_axis_tuser[1] !== want.sat)
                    begin
                        report_mismatch("saturated", longint'(m_axis_tuser[1]),
                                        longint'(want.sat));
                    end
                end
            end
            if (psel && penable && pready)
            begin
                idx = paddr[APB_ADDR_W-1:2];
                if (pwrite)
                begin
                    coef_regs[int'(idx)] = coef_t'(pwdata);
                end
                else if (prdata !== coef_regs[int'(idx)])
                begin
                    report_mismatch("register readback", longint'(prdata),
                                    longint'(unsigned'(coef_regs[int'(idx)])));
                end
            end
        end
    end

    // Sample driver: hold a word until taken, then offer the next or idle.
    always @(negedge clk)
    begin
        filter_word_t w;
        if (rst_n && !(s_axis_tvalid && words_in < driven_count))
        begin
            if (pending_samples.size() != 0 && (quiet || $urandom_range(99) >= 16))
            begin
                w = pending_samples.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= w.sample;
                s_axis_tuser  <= w.chan;
                driven_count  <= driven_count + 1;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Output receiver: random back-pressure, plus one long hold-off on request.
    always @(negedge clk)
    begin
        if (hold_req && !hold_done)
        begin
            hold_count++;
            if (hold_count >= HOLD_CYCLES)
            begin
                hold_done <= 1'b1;
                m_axis_tready <= 1'b1;
            end
            else
            begin
                m_axis_tready <= 1'b0;
            end
        end
        else
        begin
            m_axis_tready <= quiet || ($urandom_range(99) >= 16);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (psel && penable))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    task automatic apb_access(bit wr, reg_idx_t idx, coef_t value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_coefs(coef_t b0, coef_t b1, coef_t b2, coef_t a1, coef_t a2);
        apb_access(1'b1, REG_B0, b0);
        apb_access(1'b1, REG_B1, b1);
        apb_access(1'b1, REG_B2, b2);
        apb_access(1'b1, REG_A1, a1);
        apb_access(1'b1, REG_A2, a2);
        for (int i = 0; i < NUM_COEFS; i++)
        begin
            apb_access(1'b0, reg_idx_t'(i), '0);
        end
    endtask

    task automatic push_word(chan_t chan, sample_t sample);
        filter_word_t w;
        w.chan = chan;
        w.sample = sample;
        pending_samples.push_back(w);
    endtask

    task automatic wait_idle();
        while (pending_samples.size() != 0 || words_in != driven_count
               || expected_outputs.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic queue_random(int count);
        bit      alternate;
        chan_t   chan;
        sample_t sample;
        alternate = 1'($urandom_range(1));
        chan = chan_t'($urandom_range(1));
        for (int i = 0; i < count; i++)
        begin
            if (alternate)
            begin
                chan = ~chan;
            end
            else
            begin
                chan = chan_t'($urandom_range(1));
            end
            case ($urandom_range(9))
                0: sample = SAMPLE_MAX;
                1: sample = SAMPLE_MIN;
                2: sample = sample_t'(int'($urandom_range(64)) - 32);
                3: sample = sample_t'(int'($urandom_range(32'h0001_0000)) - 32'sh0000_8000);
                default: sample = sample_t'($urandom);
            endcase
            push_word(chan, sample);
        end
    endtask

    function automatic coef_t near_unity();
        return coef_t'(int'($urandom_range(32'h0800_0000)) - 32'sh0400_0000);
    endfunction

    initial
    begin
        coef_regs[REG_B0] = COEF_ONE;
        coef_regs[REG_B1] = '0;
        coef_regs[REG_B2] = '0;
        coef_regs[REG_A1] = '0;
        coef_regs[REG_A2] = '0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            x_hist[c][0] = '0;
            x_hist[c][1] = '0;
            y_hist[c][0] = '0;
            y_hist[c][1] = '0;
        end
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Pass-through at reset coefficients, field extremes, a same-channel run.
        push_word(1'b0, '0);
        push_word(1'b1, SAMPLE_MAX);
        push_word(1'b0, SAMPLE_MIN);
        push_word(1'b1, sample_t'(-1));
        push_word(1'b0, sample_t'(1));
        push_word(1'b0, sample_t'(24'h555555));
        push_word(1'b1, sample_t'(24'hAAAAAA));
        wait_idle();

        // Half gain: ties round upwards.
        load_coefs(COEF_ONE >>> 1, '0, '0, '0, '0);
        push_word(1'b0, sample_t'(1));
        push_word(1'b1, sample_t'(-1));
        push_word(1'b0, sample_t'(3));
        push_word(1'b1, sample_t'(-3));
        wait_idle();

        // First-order section: unused taps zero.
        load_coefs(COEF_ONE >>> 1, COEF_ONE >>> 1, '0, COEF_ONE >>> 1, '0);
        push_word(1'b0, sample_t'(24'h123456));
        push_word(1'b0, sample_t'(24'h7FF000));
        push_word(1'b1, sample_t'(24'hF00001));
        push_word(1'b1, sample_t'(-5));
        wait_idle();

        // Coefficient extremes: clip both ways and feed clipped outputs back.
        load_coefs(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF);
        push_word(1'b0, SAMPLE_MAX);
        push_word(1'b0, SAMPLE_MIN);
        push_word(1'b1, SAMPLE_MIN);
        push_word(1'b1, SAMPLE_MAX);
        push_word(1'b0, '0);
        wait_idle();

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: load_coefs(32'sh01000000, 32'sh02000000, 32'sh01000000,
                              32'sh03000000, 32'shFF000000);
                1: load_coefs(near_unity(), near_unity(), near_unity(),
                              near_unity() >>> 1, near_unity() >>> 2);
                2: load_coefs(coef_t'($urandom), coef_t'($urandom), coef_t'($urandom),
                              coef_t'($urandom), coef_t'($urandom));
                3: load_coefs(32'sh00800000, 32'sh01000000, 32'sh00800000,
                              32'sh05000000, 32'shFD800000);
                4: load_coefs(32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000,
                              32'sh7FFFFFFF, 32'sh80000000);
                default: load_coefs(near_unity(), near_unity(), near_unity(),
                                    near_unity(), near_unity() >>> 1);
            endcase
            quiet = (phase == 2);
            if (phase == 3)
            begin
                hold_req = 1'b1;
            end
            queue_random(PHASE_WORDS);
            wait_idle();
        end
        quiet = 1'b0;

        if (expected_outputs.size() != 0)
        begin
            report_mismatch("words left over", longint'(expected_outputs.size()), 0);
        end
        $display("run covered %0d words in and %0d out across 10 coefficient sets",
                 words_in, words_out);
        $display("%0d outputs clipped, %0d cycles of input back-pressure", sat_count, in_stalls);
        if (errors == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
+incdir+design
design/bqf_pkg.sv
design/bqf_regs.sv
design/bqf_front.sv
design/bqf_back.sv
design/biquad_iir_filter.sv
sim/biquad_iir_filter_tb.sv
